FILE: rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

  // Sizing of the list and of the beat fields.
  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int MODE_W     = 3;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int OUT_CNT_W  = 7;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // First-match scan is split into groups of cells.
  localparam int GROUP_SZ   = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;
  localparam int SCAN_W     = NUM_GROUPS * GROUP_SZ;

  typedef logic signed [DATA_W-1:0] data_t;

  // Value returned by a pop on an empty list.
  localparam data_t POP_EMPTY_VAL = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT  = 3'd0,
    MODE_PUSH_BACK   = 3'd1,
    MODE_INSERT_AT   = 3'd2,
    MODE_POP_FRONT   = 3'd3,
    MODE_POP_BACK    = 3'd4,
    MODE_REMOVE_VAL  = 3'd5,
    MODE_SEARCH      = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // What a cell loads into its entry register on a given cycle.
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_LOAD       = 2'd1,
    OP_TAKE_LEFT  = 2'd2,
    OP_TAKE_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     live;   // the cell holds a valid entry
    logic     pick;   // the cell is the one a pop reads
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bounded_ordered_list_engine_core.sv
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries, index 0 at the front,
// held in a row of cells that each own one entry and can load a new value or
// take their left or right neighbour's value. One request beat carries a mode
// (push front, push back, insert at position, pop front, pop back, remove the
// first equal entry, or search) and yields exactly one result beat with a
// status, a value, a found flag and the count after the request. A request
// passes through the states match, in which every cell compares its entry with
// the key, then group and prefix, the steps of the grouped first-match scan that
// also collects the popped entry, and apply, in which all cells shift at once
// and the result register loads. The block then returns to idle, ready for
// the next request; it takes no new request before the last one is through,
// and a result that waits holds both the last step and the acceptance of the
// next request. Entries are undefined after reset and only entries below the
// count are ever read; the count resets to zero.

module bounded_ordered_list_engine_core import bole_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [DATA_W-1:0]   in_item_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_result_value,
  output logic                       out_found,
  output logic [OUT_CNT_W-1:0]       out_entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_PREFIX,
    S_APPLY
  } state_t;

  state_t           state_r;
  mode_t            mode_r;
  logic [POS_W-1:0] pos_r;
  data_t            key_r;
  logic [CNT_W-1:0] count_r;

  logic             out_valid_r;
  status_t          out_status_r;
  data_t            out_result_r;
  logic             out_found_r;
  logic [CNT_W-1:0] out_count_r;

  logic in_fire;
  logic apply_fire;

  // Cell row wiring.
  cell_ctl_t           cell_ctl [CAPACITY];
  data_t               cell_val [CAPACITY];
  data_t               cell_pick[CAPACITY];
  logic [CAPACITY-1:0] cell_eq;

  // Scan results.
  logic [CAPACITY-1:0] after_r;
  logic                any_r;
  data_t               rd_val_r;

  // Decode of the request in the apply cycle.
  logic             full;
  logic             empty;
  logic             do_insert;
  logic             do_remove;
  logic [CNT_W-1:0] ins_idx;
  logic [CNT_W-1:0] rm_idx;
  logic [CNT_W-1:0] pick_idx;
  logic [CNT_W-1:0] count_nxt;
  status_t          status_nxt;
  data_t            result_nxt;
  logic             found_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  // The last step waits for room in the result register.
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // A pop front reads the first cell, a pop back the last live one.
  assign pick_idx = (mode_r == MODE_POP_FRONT) ? '0 : count_r - 1'b1;

  always_comb begin
    status_nxt = ST_OK;
    result_nxt = '0;
    found_nxt  = 1'b0;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    ins_idx    = '0;
    rm_idx     = '0;
    count_nxt  = count_r;
    case (mode_r)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_insert = 1'b1;
          ins_idx   = (mode_r == MODE_PUSH_FRONT) ? '0 : count_r;
        end
      end
      MODE_INSERT_AT: begin
        // The position check takes precedence over the full check.
        if (CNT_W'(pos_r) > count_r || (POS_W > CNT_W && pos_r > POS_W'(CAPACITY))) begin
          status_nxt = ST_BAD_INDEX;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_insert = 1'b1;
          ins_idx   = CNT_W'(pos_r);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
          result_nxt = POP_EMPTY_VAL;
        end else begin
          do_remove  = 1'b1;
          rm_idx     = pick_idx;
          result_nxt = rd_val_r;
        end
      end
      MODE_REMOVE_VAL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (any_r) begin
          do_remove = 1'b1;
          found_nxt = 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      MODE_SEARCH: begin
        if (any_r) begin
          found_nxt = 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        // The unused mode leaves the list alone and answers ok.
      end
    endcase
    if (do_insert) begin
      count_nxt = count_r + 1'b1;
    end else if (do_remove) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Each cell decides its own move from its index against the insert or
  // removal point; a removal by value uses the scanned first-match mask.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic rm_here;

    assign rm_here = (mode_r == MODE_REMOVE_VAL) ? after_r[i] : (CNT_W'(i) >= rm_idx);

    always_comb begin
      cell_ctl[i].live = (CNT_W'(i) < count_r);
      cell_ctl[i].pick = (CNT_W'(i) == pick_idx);
      cell_ctl[i].op   = OP_HOLD;
      if (apply_fire) begin
        if (do_insert) begin
          if (CNT_W'(i) > ins_idx) begin
            cell_ctl[i].op = OP_TAKE_LEFT;
          end else if (CNT_W'(i) == ins_idx) begin
            cell_ctl[i].op = OP_LOAD;
          end
        end else if (do_remove && rm_here) begin
          cell_ctl[i].op = OP_TAKE_RIGHT;
        end
      end
    end

    bole_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .key        (key_r),
      .load_val   (key_r),
      .left_val   ((i == 0) ? data_t'('0) : cell_val[(i == 0) ? 0 : i - 1]),
      .right_val  ((i == CAPACITY - 1) ? data_t'('0)
                                       : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .entry_r    (cell_val[i]),
      .eq_r       (cell_eq[i]),
      .pick_val_r (cell_pick[i])
    );
  end

  bole_scan u_scan (
    .clk      (clk),
    .eq       (cell_eq),
    .pick_val (cell_pick),
    .after_r  (after_r),
    .any_r    (any_r),
    .rd_val_r (rd_val_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_MATCH;
          end
        end
        S_MATCH:  state_r <= S_GROUP;
        S_GROUP:  state_r <= S_PREFIX;
        S_PREFIX: state_r <= S_APPLY;
        S_APPLY: begin
          if (apply_fire) begin
            state_r <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase

      if (apply_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_fire) begin
      mode_r <= mode_t'(in_mode);
      pos_r  <= in_position;
      key_r  <= in_item_value;
    end

    if (apply_fire) begin
      out_status_r <= status_nxt;
      out_result_r <= result_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_result_r;
  assign out_found        = out_found_r;
  assign out_entry_count  = OUT_CNT_W'(out_count_r);

endmodule

`default_nettype wire

FILE: rtl/bole_cell.sv
`default_nettype none

module bole_cell import bole_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  data_t     key,
  input  data_t     load_val,
  input  data_t     left_val,
  input  data_t     right_val,
  output data_t     entry_r,
  output logic      eq_r,
  output data_t     pick_val_r
);

  data_t entry_nxt;

  always_comb begin
    case (ctl.op)
      OP_HOLD:       entry_nxt = entry_r;
      OP_LOAD:       entry_nxt = load_val;
      OP_TAKE_LEFT:  entry_nxt = left_val;
      OP_TAKE_RIGHT: entry_nxt = right_val;
      default:       entry_nxt = entry_r;
    endcase
  end

  // The compare and the masked read are registered every cycle; the
  // sequencer samples them when the request operands are settled.
  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    eq_r       <= ctl.live && (entry_r == key);
    pick_val_r <= ctl.pick ? entry_r : '0;
  end

endmodule

`default_nettype wire

FILE: rtl/bole_scan.sv
`default_nettype none

module bole_scan import bole_pkg::*; (
  input  logic                clk,
  input  logic [CAPACITY-1:0] eq,
  input  data_t               pick_val [CAPACITY],
  output logic [CAPACITY-1:0] after_r,
  output logic                any_r,
  output data_t               rd_val_r
);

  logic [SCAN_W-1:0]   eq_pad;
  data_t               val_pad [SCAN_W];
  logic [GROUP_SZ-1:0] grp_pre_nxt [NUM_GROUPS];
  logic [GROUP_SZ-1:0] grp_pre_r   [NUM_GROUPS];
  logic                grp_any_nxt [NUM_GROUPS];
  logic                grp_any_r   [NUM_GROUPS];
  data_t               grp_val_nxt [NUM_GROUPS];
  data_t               grp_val_r   [NUM_GROUPS];
  logic [SCAN_W-1:0]   after_nxt;
  logic                any_nxt;
  data_t               rd_val_nxt;

  for (genvar gi = 0; gi < SCAN_W; gi++) begin : g_pad
    if (gi < CAPACITY) begin : g_real
      assign eq_pad[gi]  = eq[gi];
      assign val_pad[gi] = pick_val[gi];
    end else begin : g_fill
      assign eq_pad[gi]  = 1'b0;
      assign val_pad[gi] = '0;
    end
  end

  // First step: running OR inside each group of cells.
  always_comb begin
    logic  acc;
    data_t vacc;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      acc  = 1'b0;
      vacc = '0;
      for (int j = 0; j < GROUP_SZ; j++) begin
        acc               = acc | eq_pad[g*GROUP_SZ + j];
        vacc              = vacc | val_pad[g*GROUP_SZ + j];
        grp_pre_nxt[g][j] = acc;
      end
      grp_any_nxt[g] = acc;
      grp_val_nxt[g] = vacc;
    end
  end

  // Second step: carry the group results along the row.
  always_comb begin
    logic carry;
    carry      = 1'b0;
    rd_val_nxt = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int j = 0; j < GROUP_SZ; j++) begin
        after_nxt[g*GROUP_SZ + j] = grp_pre_r[g][j] | carry;
      end
      carry      = carry | grp_any_r[g];
      rd_val_nxt = rd_val_nxt | grp_val_r[g];
    end
    any_nxt = carry;
  end

  always_ff @(posedge clk) begin
    grp_pre_r <= grp_pre_nxt;
    grp_any_r <= grp_any_nxt;
    grp_val_r <= grp_val_nxt;
    after_r   <= after_nxt[CAPACITY-1:0];
    any_r     <= any_nxt;
    rd_val_r  <= rd_val_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/bole_checker.sv
`default_nettype none

module bole_checker import bole_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [STATUS_W-1:0]      out_status,
  input  logic signed [DATA_W-1:0] out_result_value,
  input  logic                     out_found,
  input  logic [OUT_CNT_W-1:0]     out_entry_count
);

  // A full refusal can only be reported at capacity.
  a_full_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_entry_count == OUT_CNT_W'(CAPACITY))
    else $error("full status with spare room");

  // An empty status means the list really is empty.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> out_entry_count == '0)
    else $error("empty status with entries present");

  // A pop on an empty list answers minus one; other empty answers give zero.
  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY)
      |-> (out_result_value == POP_EMPTY_VAL || out_result_value == '0))
    else $error("bad value with empty status");

  // A match is always a successful request.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_status == ST_OK)
    else $error("found flag with failing status");

  // A request is not taken while the previous one is still being worked on.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

endmodule

bind bounded_ordered_list_engine_core bole_checker u_bole_checker (.*);

`default_nettype wire
